FILE: hw/rtl/poly2d_monomial_basis_macros.svh
// ----------------------------------------------------------------------------
// poly2d_monomial_basis assertion macros
// Concurrent check wrappers; defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef POLY2D_MONOMIAL_BASIS_MACROS_SVH
`define POLY2D_MONOMIAL_BASIS_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold on every clock edge outside reset
`define P2MB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("p2mb: property check failed");

// condition must never be true outside reset
`define P2MB_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("p2mb: illegal condition seen");

`else

`define P2MB_ASSERT(lbl, clk, rst, prop)
`define P2MB_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: hw/rtl/p2mb_pkg.sv
// ----------------------------------------------------------------------------
// p2mb_pkg
// Shared widths, constants and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package p2mb_pkg;

   localparam int MAX_ORDER     = 9;
   localparam int FRAC_BITS     = 16;
   localparam int MAX_ORDER_RST = 2;

   localparam int CRD_W     = 24;                 // input coordinate width
   localparam int VAL_W     = 48;                 // term / power width
   localparam int HALF_W    = VAL_W / 2;          // multiplier operand width
   localparam int ACC_W     = 2 * VAL_W;          // full product width
   localparam int Q_W       = ACC_W - FRAC_BITS;  // product after scaling
   localparam int ORD_W     = 4;                  // max_order register width
   localparam int NUM_POW   = MAX_ORDER + 1;
   localparam int IDX_W     = $clog2(NUM_POW);
   localparam int NUM_TERMS = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2;
   localparam int KIDX_W    = $clog2(NUM_TERMS);
   localparam int MUL_STEPS = 4;                  // 24x24 partial products
   localparam int PP_W      = $clog2(MUL_STEPS);
   localparam int CNT_W     = $clog2(MUL_STEPS + 1);

   localparam logic [VAL_W-1:0] POS_LIM = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] NEG_MAG = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [VAL_W-1:0] FX_ONE  = VAL_W'(1) << FRAC_BITS;

   // what the current multiply is for
   typedef enum logic [1:0] {
      PH_POWX = 2'd0,
      PH_POWY = 2'd1,
      PH_TERM = 2'd2
   } phase_type;

   typedef struct packed {
      logic              start;     // latch point, seed powers with 1.0
      logic              op_ld;     // load operand magnitudes, clear acc
      logic              mul_en;    // issue one partial product
      logic              acc_en;    // add registered partial product
      logic [PP_W-1:0]   pp_sel;
      logic              round;     // scale and round toward -inf
      logic              sat_wr;    // saturate, write power or term
      logic              emit;      // load output register
      phase_type         phase;
      logic [IDX_W-1:0]  idx_a;
      logic [IDX_W-1:0]  idx_b;
      logic [IDX_W-1:0]  idx_w;
      logic [KIDX_W-1:0] term_index;
      logic              last_term;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/p2mb_if.sv
// ----------------------------------------------------------------------------
// p2mb channel interfaces
// Valid/ready channels for input points and output terms.
// ----------------------------------------------------------------------------
`default_nettype none

interface p2mb_req_if import p2mb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [CRD_W-1:0] x_coord;
   logic signed [CRD_W-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface p2mb_rsp_if import p2mb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] term_value;
   logic [KIDX_W-1:0]       term_index;
   logic                    last_term;

   modport source (output valid, output term_value, output term_index,
                   output last_term, input ready);
   modport sink   (input valid, input term_value, input term_index,
                   input last_term, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/poly2d_monomial_basis.sv
// ----------------------------------------------------------------------------
// poly2d_monomial_basis
// Bivariate polynomial monomial basis generator, signed fixed point Q.16.
// ----------------------------------------------------------------------------
// For each point (x, y) accepted on req_chan the block sends one beat per
// monomial on rsp_chan, order by order up to max_order (clamped to 9): 1, x,
// y, x^2, xy, y^2, ... Each beat carries the term value (48-bit, 16 fraction
// bits, saturated), its index from 0 and a last_term flag on the final beat.
// Every product is floored and saturated, powers first: x^r and y^r are built
// by repeated multiply, then each term is x^(n-i)*y^i. All multiplies share
// one 24x24 multiplier over four partial products; each multiply runs through
// operand load, the partial-product issues plus an accumulate drain, round and
// saturate, and each term then also loads the output register. One point is in
// flight at a time; the next is taken as soon as the last term sits in the
// output register. max_order is written through csr_wr_en / csr_wr_data; the
// user must write it only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

`include "poly2d_monomial_basis_macros.svh"

module poly2d_monomial_basis import p2mb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [ORD_W-1:0] csr_wr_data,
   p2mb_req_if.sink              req_chan,
   p2mb_rsp_if.source            rsp_chan
);

   cmd_type  dp_cmd;   // sequencer -> datapath
   stat_type dp_stat;  // datapath -> sequencer

   // sequencer: owns max_order, loop counters and term index
   p2mb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .cmd         (dp_cmd),
      .stat        (dp_stat)
   );

   // datapath: power tables, shared multiplier, rsp output register
   p2mb_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .stat           (dp_stat),
      .x_coord        (req_chan.x_coord),
      .y_coord        (req_chan.y_coord),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_term_value (rsp_chan.term_value),
      .rsp_term_index (rsp_chan.term_index),
      .rsp_last_term  (rsp_chan.last_term)
   );

   // an accepted point always takes the sequencer out of idle
   `P2MB_ASSERT(a_req_leaves_idle, clock, reset, req_chan.valid && req_chan.ready |=> !req_chan.ready)

   // a term is never loaded over an output beat that has not been taken
   `P2MB_NEVER(a_emit_overwrite, clock, reset, dp_cmd.emit && !dp_stat.out_free)

endmodule

`default_nettype wire

FILE: hw/rtl/p2mb_ctrl.sv
// ----------------------------------------------------------------------------
// p2mb_ctrl
// Sequencer: power build-up (skipped at order 0), then term walk, one shared multiply at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module p2mb_ctrl import p2mb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [ORD_W-1:0] csr_wr_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output cmd_type               cmd,
   input  wire stat_type         stat
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_OPLD = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_RND  = 6'b001000,
      ST_SAT  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [ORD_W-1:0]  max_order_ff, max_order_in;
   logic [IDX_W-1:0]  ord_ff, ord_in;
   logic [IDX_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [KIDX_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  ord_clamp;
   logic              at_last;

   assign ord_clamp = (max_order_ff > ORD_W'(MAX_ORDER)) ? IDX_W'(MAX_ORDER)
                                                         : IDX_W'(max_order_ff);
   assign at_last   = (n_ff == ord_ff) && (i_ff == n_ff);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      max_order_in = csr_wr_en ? csr_wr_data : max_order_ff;
      ord_in       = ord_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;

      cmd            = '0;
      cmd.phase      = phase_ff;
      cmd.idx_a      = (phase_ff == PH_TERM) ? (n_ff - i_ff) : (n_ff - IDX_W'(1));
      cmd.idx_b      = i_ff;
      cmd.idx_w      = n_ff;
      cmd.term_index = k_ff;
      cmd.last_term  = at_last;
      cmd.pp_sel     = cnt_ff[PP_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               ord_in    = ord_clamp;
               k_in      = '0;
               i_in      = '0;
               if (ord_clamp == '0) begin
                  phase_in = PH_TERM;
                  n_in     = '0;
               end else begin
                  phase_in = PH_POWX;
                  n_in     = IDX_W'(1);
               end
               state_in = ST_OPLD;
            end
         end
         ST_OPLD: begin
            cmd.op_ld = 1'b1;
            cnt_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            // products issue on counts 0..3 and accumulate on counts 1..4
            cmd.mul_en = (cnt_ff < CNT_W'(MUL_STEPS));
            cmd.acc_en = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(MUL_STEPS)) begin
               state_in = ST_RND;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_RND: begin
            cmd.round = 1'b1;
            state_in  = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat_wr = 1'b1;
            case (phase_ff)
               PH_POWX: begin
                  phase_in = PH_POWY;
                  state_in = ST_OPLD;
               end
               PH_POWY: begin
                  if (n_ff == ord_ff) begin
                     phase_in = PH_TERM;
                     n_in     = '0;
                     i_in     = '0;
                  end else begin
                     phase_in = PH_POWX;
                     n_in     = n_ff + IDX_W'(1);
                  end
                  state_in = ST_OPLD;
               end
               PH_TERM: begin
                  state_in = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + KIDX_W'(1);
                  if (i_ff == n_ff) begin
                     n_in = n_ff + IDX_W'(1);
                     i_in = '0;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
                  state_in = ST_OPLD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_POWX;
         max_order_ff <= ORD_W'(MAX_ORDER_RST);
         ord_ff       <= '0;
         n_ff         <= '0;
         i_ff         <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         max_order_ff <= max_order_in;
         ord_ff       <= ord_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/p2mb_dpath.sv
// ----------------------------------------------------------------------------
// p2mb_dpath
// Power tables, shared 24x24 sign-magnitude multiplier, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module p2mb_dpath import p2mb_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   input  wire logic signed [CRD_W-1:0] x_coord,
   input  wire logic signed [CRD_W-1:0] y_coord,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [VAL_W-1:0]      rsp_term_value,
   output logic [KIDX_W-1:0]            rsp_term_index,
   output logic                         rsp_last_term
);

   function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] v);
      return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
   endfunction

   logic signed [CRD_W-1:0]  x_ff, y_ff;
   logic signed [VAL_W-1:0]  xp_ff [NUM_POW];
   logic signed [VAL_W-1:0]  yp_ff [NUM_POW];
   logic [VAL_W-1:0]         mag_a_ff, mag_b_ff;
   logic                     neg_ff;
   logic [2*HALF_W-1:0]      prod_ff;
   logic [1:0]               sh_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic [Q_W-1:0]           q_ff;
   logic signed [VAL_W-1:0]  res_ff;
   logic                     out_valid_ff, out_valid_in;
   logic signed [VAL_W-1:0]  out_value_ff;
   logic [KIDX_W-1:0]        out_index_ff;
   logic                     out_last_ff;

   logic [VAL_W-1:0]         opa, opb;
   logic [HALF_W-1:0]        half_a, half_b;
   logic [ACC_W-1:0]         pp_shifted;
   logic [VAL_W-1:0]         lim, sat_mag;
   logic signed [VAL_W-1:0]  sat_val;

   // operand select
   always_comb begin
      case (cmd.phase)
         PH_POWX: begin
            opa = xp_ff[cmd.idx_a];
            opb = {{(VAL_W-CRD_W){x_ff[CRD_W-1]}}, x_ff};
         end
         PH_POWY: begin
            opa = yp_ff[cmd.idx_a];
            opb = {{(VAL_W-CRD_W){y_ff[CRD_W-1]}}, y_ff};
         end
         default: begin
            opa = xp_ff[cmd.idx_a];
            opb = yp_ff[cmd.idx_b];
         end
      endcase
   end

   assign half_a = cmd.pp_sel[0] ? mag_a_ff[VAL_W-1:HALF_W] : mag_a_ff[HALF_W-1:0];
   assign half_b = cmd.pp_sel[1] ? mag_b_ff[VAL_W-1:HALF_W] : mag_b_ff[HALF_W-1:0];

   always_comb begin
      case (sh_ff)
         2'd0:    pp_shifted = ACC_W'(prod_ff);
         2'd1:    pp_shifted = ACC_W'(prod_ff) << HALF_W;
         default: pp_shifted = ACC_W'(prod_ff) << (2 * HALF_W);
      endcase
   end

   // saturate magnitude to the signed range, then apply sign
   assign lim     = neg_ff ? NEG_MAG : POS_LIM;
   assign sat_mag = ((q_ff[Q_W-1:VAL_W] != '0) || (q_ff[VAL_W-1:0] > lim))
                    ? lim : q_ff[VAL_W-1:0];
   assign sat_val = neg_ff ? -$signed(sat_mag) : $signed(sat_mag);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff     <= x_coord;
         y_ff     <= y_coord;
         xp_ff[0] <= FX_ONE;
         yp_ff[0] <= FX_ONE;
      end
      if (cmd.op_ld) begin
         mag_a_ff <= mag_of(opa);
         mag_b_ff <= mag_of(opb);
         neg_ff   <= opa[VAL_W-1] ^ opb[VAL_W-1];
      end
      if (cmd.mul_en) begin
         prod_ff <= half_a * half_b;
         sh_ff   <= {1'b0, cmd.pp_sel[0]} + {1'b0, cmd.pp_sel[1]};
      end
      if (cmd.op_ld) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + pp_shifted;
      end
      if (cmd.round) begin
         // floor of a negative result: bump magnitude if bits were dropped
         q_ff <= Q_W'(acc_ff >> FRAC_BITS)
                 + Q_W'(neg_ff && (acc_ff[FRAC_BITS-1:0] != '0));
      end
      if (cmd.sat_wr) begin
         case (cmd.phase)
            PH_POWX: xp_ff[cmd.idx_w] <= sat_val;
            PH_POWY: yp_ff[cmd.idx_w] <= sat_val;
            default: res_ff           <= sat_val;
         endcase
      end
      if (cmd.emit) begin
         out_value_ff <= res_ff;
         out_index_ff <= cmd.term_index;
         out_last_ff  <= cmd.last_term;
      end
   end

   always_comb begin
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign stat.out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid      = out_valid_ff;
   assign rsp_term_value = out_value_ff;
   assign rsp_term_index = out_index_ff;
   assign rsp_last_term  = out_last_ff;

endmodule

`default_nettype wire
